// ===== design/ped_pkg.sv =====
`default_nettype none
package ped_pkg;

  // Fixed field widths of the distance engine.
  localparam int unsigned SumW      = 43;
  localparam int unsigned DistW     = 30;
  localparam int unsigned IdxW      = 16;
  localparam int unsigned RowsW     = 17;
  localparam int unsigned FcCfgW    = 11;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 17;

  // Square root unit: radicand is the sum shifted up by 16, padded to an even width.
  localparam int unsigned RadW      = 60;
  localparam int unsigned RemW      = 33;
  localparam int unsigned RootSteps = 30;
  localparam int unsigned StepW     = 5;

  localparam logic [SumW-1:0]   SumMax     = {SumW{1'b1}};
  localparam logic [FcCfgW-1:0] FcReset    = 11'd128;
  localparam logic [RowsW-1:0]  RowsAReset = 17'd16384;
  localparam logic [RowsW-1:0]  RowsBReset = 17'd4096;
  localparam logic [RowsW-1:0]  RowsMax    = 17'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FEATURE_COUNT = 2'd0,
    CFG_ROWS_A        = 2'd1,
    CFG_ROWS_B        = 2'd2
  } cfg_reg_e;

endpackage
`default_nettype wire

// ===== design/ped_if.sv =====
`default_nettype none

// Feature pair channel.
interface ped_feat_if #(
  parameter int unsigned SW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] a_value;
  logic signed [SW-1:0] b_value;

  modport source (output valid, a_value, b_value, input ready);
  modport sink   (input valid, a_value, b_value, output ready);
endinterface

// Distance result channel.
interface ped_res_if;
  import ped_pkg::*;
  logic             valid;
  logic             ready;
  logic [DistW-1:0] distance;
  logic [IdxW-1:0]  row_index;
  logic [IdxW-1:0]  column_index;
  logic             last_pair;

  modport source (output valid, distance, row_index, column_index, last_pair, input ready);
  modport sink   (input valid, distance, row_index, column_index, last_pair, output ready);
endinterface

// Register write channel.
interface ped_cfg_if;
  import ped_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/pairwise_euclidean_distance_top.sv =====
`default_nettype none
// Channel   Dir   Interface     Payload
// feat_i    in    ped_feat_if   a_value, b_value (signed, SAMPLE_WIDTH bits)
// res_o     out   ped_res_if    distance, row_index, column_index, last_pair
// cfg_i     in    ped_cfg_if    index (0 feature_count, 1 rows_a, 2 rows_b), data
//
// A feature pair goes through accept, square and accumulate in turn.
// The last feature of a vector pair then runs through the shared restoring square root
// unit (one root bit per cycle), then the flush state fills the output register.
// The output register holds a result while the next pairs are accepted; a stalled result
// holds the following square root result in the flush state, and feature input with it.
// Reset is asynchronous and active low; it restores the register defaults and clears
// all counters and the accumulator. Register writes are always accepted.
module pairwise_euclidean_distance_top #(
  parameter int unsigned MAX_FEATURES = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ped_feat_if.sink   feat_i,
  ped_res_if.source  res_o,
  ped_cfg_if.sink    cfg_i
);
  import ped_pkg::*;

  // Absolute difference, its square and the widened accumulator sum.
  localparam int unsigned DW      = SAMPLE_WIDTH + 1;
  localparam int unsigned SqW     = 2 * DW;
  localparam int unsigned AccW    = ((SqW > SumW) ? SqW : SumW) + 1;
  // The feature count register has 11 bits, so the usable maximum is also capped there.
  localparam int unsigned FcMax   = (MAX_FEATURES < 2047) ? MAX_FEATURES : 2047;
  localparam int unsigned FcCntW  = (FcMax > 1) ? $clog2(FcMax) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_ROOT,
    S_FLUSH
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [FcCfgW-1:0] fc_cfg_q;
  logic [RowsW-1:0]  ra_cfg_q, rb_cfg_q;

  // Stream position.
  logic [FcCntW-1:0] fcnt_q;
  logic [IdxW-1:0]   row_q, col_q;

  // Datapath.
  logic [DW-1:0]     ad_q;
  logic [SqW-1:0]    sq_q;
  logic [SumW-1:0]   sum_q;
  logic              last_q;
  logic [IdxW-1:0]   pend_row_q, pend_col_q;
  logic              pend_last_q;

  // Square root unit.
  logic [RadW-1:0]   rad_q;
  logic [RemW-1:0]   rem_q;
  logic [DistW-1:0]  root_q;
  logic [StepW-1:0]  step_q;

  // Output register.
  logic              res_valid_q;
  logic [DistW-1:0]  res_dist_q;
  logic [IdxW-1:0]   res_row_q, res_col_q;
  logic              res_last_q;

  // Effective limits: zero acts as one, oversize values are clamped.
  logic [FcCfgW-1:0] fc_eff;
  logic [RowsW-1:0]  ra_eff, rb_eff;

  always_comb begin
    if (fc_cfg_q == '0) begin
      fc_eff = FcCfgW'(1);
    end else if (fc_cfg_q > FcCfgW'(FcMax)) begin
      fc_eff = FcCfgW'(FcMax);
    end else begin
      fc_eff = fc_cfg_q;
    end
    if (ra_cfg_q == '0) begin
      ra_eff = RowsW'(1);
    end else if (ra_cfg_q > RowsMax) begin
      ra_eff = RowsMax;
    end else begin
      ra_eff = ra_cfg_q;
    end
    if (rb_cfg_q == '0) begin
      rb_eff = RowsW'(1);
    end else if (rb_cfg_q > RowsMax) begin
      rb_eff = RowsMax;
    end else begin
      rb_eff = rb_cfg_q;
    end
  end

  // A counter at or past its last value counts as being at its last value,
  // which covers limits lowered in the middle of a stream.
  logic feat_last, col_last, row_last;
  assign feat_last = ({1'b0, FcCfgW'(fcnt_q)} + (FcCfgW + 1)'(1)) >= {1'b0, fc_eff};
  assign col_last  = ({1'b0, col_q} + RowsW'(1)) >= rb_eff;
  assign row_last  = ({1'b0, row_q} + RowsW'(1)) >= ra_eff;

  // Difference of the two samples in one extra bit, then its magnitude.
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        abs_diff;
  assign diff     = $signed({feat_i.a_value[SAMPLE_WIDTH-1], feat_i.a_value})
                  - $signed({feat_i.b_value[SAMPLE_WIDTH-1], feat_i.b_value});
  assign abs_diff = diff[DW-1] ? DW'(-diff) : DW'(diff);

  // Saturating accumulate.
  logic [AccW-1:0] sum_wide;
  logic [SumW-1:0] sum_sat;
  assign sum_wide = AccW'(sum_q) + AccW'(sq_q);
  assign sum_sat  = (sum_wide > AccW'(SumMax)) ? SumMax : sum_wide[SumW-1:0];

  // One restoring square root step: bring down two radicand bits, try to subtract.
  logic [RemW-1:0]  rem_sh, trial;
  logic             take;
  logic [RemW-1:0]  rem_next;
  logic [DistW-1:0] root_next;
  assign rem_sh    = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign take      = rem_sh >= trial;
  assign rem_next  = take ? (rem_sh - trial) : rem_sh;
  assign root_next = {root_q[DistW-2:0], take};

  // Handshake outputs.
  assign feat_i.ready       = (state_q == S_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign res_o.valid        = res_valid_q;
  assign res_o.distance     = res_dist_q;
  assign res_o.row_index    = res_row_q;
  assign res_o.column_index = res_col_q;
  assign res_o.last_pair    = res_last_q;

  // The output register takes a new result when it is empty or its current
  // result transfers in the same cycle.
  logic res_load;
  assign res_load = (state_q == S_FLUSH) && (!res_valid_q || res_o.ready);

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_cfg_q <= FcReset;
      ra_cfg_q <= RowsAReset;
      rb_cfg_q <= RowsBReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_FEATURE_COUNT: fc_cfg_q <= cfg_i.data[FcCfgW-1:0];
        CFG_ROWS_A:        ra_cfg_q <= cfg_i.data[RowsW-1:0];
        CFG_ROWS_B:        rb_cfg_q <= cfg_i.data[RowsW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer with datapath and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fcnt_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      sum_q       <= '0;
      last_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      // The result leaves on its transfer unless a new one replaces it.
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (feat_i.valid) begin
            ad_q   <= abs_diff;
            last_q <= feat_last;
            if (feat_last) begin
              fcnt_q      <= '0;
              pend_row_q  <= row_q;
              pend_col_q  <= col_q;
              pend_last_q <= col_last && row_last;
              if (col_last) begin
                col_q <= '0;
                row_q <= row_last ? '0 : row_q + IdxW'(1);
              end else begin
                col_q <= col_q + IdxW'(1);
              end
            end else begin
              fcnt_q <= fcnt_q + FcCntW'(1);
            end
            state_q <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          sq_q    <= SqW'(ad_q * ad_q);
          state_q <= S_ACCUM;
        end
        S_ACCUM: begin
          if (last_q) begin
            sum_q   <= '0;
            rad_q   <= {1'b0, sum_sat, 16'h0000};
            rem_q   <= '0;
            root_q  <= '0;
            step_q  <= '0;
            state_q <= S_ROOT;
          end else begin
            sum_q   <= sum_sat;
            state_q <= S_IDLE;
          end
        end
        S_ROOT: begin
          rad_q  <= {rad_q[RadW-3:0], 2'b00};
          rem_q  <= rem_next;
          root_q <= root_next;
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(RootSteps - 1)) begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (res_load) begin
            res_dist_q  <= root_q;
            res_row_q   <= pend_row_q;
            res_col_q   <= pend_col_q;
            res_last_q  <= pend_last_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/ped_checker.sv =====
`default_nettype none
module ped_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic feat_valid,
  input wire logic feat_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire logic [29:0] res_distance,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);

  // A pending result and its distance hold until transferred.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_distance))
    else $error("result dropped or changed while stalled");

  // Each accepted feature pair occupies the datapath, so no two pairs are accepted back to back.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feat_valid && feat_ready |=> !feat_ready)
    else $error("feature pair accepted on consecutive cycles");

  // A new result only appears while the square root unit holds the input side off.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> $past(!feat_ready))
    else $error("result appeared without a square root pass");

  // Register writes never stall.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid |-> cfg_ready)
    else $error("register write stalled");

endmodule

bind pairwise_euclidean_distance_top ped_checker u_ped_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .feat_valid   (feat_i.valid),
  .feat_ready   (feat_i.ready),
  .res_valid    (res_o.valid),
  .res_ready    (res_o.ready),
  .res_distance (res_o.distance),
  .cfg_valid    (cfg_i.valid),
  .cfg_ready    (cfg_i.ready)
);
`default_nettype wire
